### sv/dif_pkg.sv
// types, limits and character codes shared by the decimal integer formatter
`default_nettype none

package dif_pkg;

  localparam int MAX_WIDTH     = 32;
  localparam int MAX_PRECISION = 16;
  localparam int OUT_LIMIT     = 32;

  // binary magnitude and its decimal form
  localparam int MAG_W  = 32;
  localparam int DIGITS = 10;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int NDIG_W = $clog2(DIGITS + 1);
  localparam int STEP_W = $clog2(MAG_W);

  // run lengths; at least wide enough for the raw width field
  localparam int CNT_RAW = $clog2(MAX_WIDTH + MAX_PRECISION + 2);
  localparam int CNT_W   = (CNT_RAW > 7) ? CNT_RAW : 7;
  localparam int LEN_W   = $clog2(OUT_LIMIT + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         field_width;
    logic [4:0]         min_digits;
    logic               left_align;
    logic               force_plus;
    logic               space_sign;
    logic               zero_fill;
    logic               short_mode;
  } num_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } chr_t;

  // layout of one number, settled when the item is taken
  typedef struct packed {
    logic [7:0]       sign_char;
    logic             has_sign;
    logic [CNT_W-1:0] width_sat;
    logic [CNT_W-1:0] prec_sat;
    logic             left;
    logic             zpad;
  } fmt_t;

endpackage

`default_nettype wire

### sv/dif_bcd.sv
// bit-serial binary to decimal conversion with leading-zero digit strip
`default_nettype none

module dif_bcd
  import dif_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [MAG_W-1:0]  mag,
  output logic                   busy,
  output logic                   done,
  output logic [BCD_W-1:0]       bcd,
  output logic [NDIG_W-1:0]      ndig
);

  typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_NORM} state_t;

  state_t            state;
  logic [MAG_W-1:0]  bin;
  logic [STEP_W-1:0] step;
  logic [BCD_W-1:0]  bcd_adj;

  // add three to every digit of five or more before the doubling shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            bin   <= mag;
            bcd   <= '0;
            step  <= STEP_W'(MAG_W - 1);
            ndig  <= NDIG_W'(DIGITS);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          bcd  <= {bcd_adj[BCD_W-2:0], bin[MAG_W-1]};
          bin  <= bin << 1;
          step <= step - STEP_W'(1);
          if (step == '0) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // bring the top digit up to the msb nibble, one digit a cycle
          if (bcd[BCD_W-1 -: 4] == 4'd0 && ndig > NDIG_W'(1)) begin
            bcd  <= bcd << 4;
            ndig <= ndig - NDIG_W'(1);
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("conversion started while busy");

  a_shift_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && step == '0) |=> state == S_NORM)
    else $error("shift phase did not end in normalise");

  a_done_digits: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE && ndig != '0 && (ndig == NDIG_W'(1) || bcd[BCD_W-1 -: 4] != 4'd0)))
    else $error("result not normalised");
`endif

endmodule

`default_nettype wire

### sv/dif_emit.sv
// sequencer: pad, sign, zeros and digits out one per unstalled cycle
`default_nettype none

module dif_emit
  import dif_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire fmt_t              fmt_in,
  input  wire logic [BCD_W-1:0]  bcd_in,
  input  wire logic [NDIG_W-1:0] ndig_in,
  output logic                   busy,
  output logic                   chr_valid,
  input  wire logic              chr_stall,
  output chr_t                   chr
);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_EMIT} state_t;

  state_t            state;
  fmt_t              fmt;
  logic [BCD_W-1:0]  dsr;
  logic [NDIG_W-1:0] dig;
  logic [CNT_W-1:0]  pre;
  logic [CNT_W-1:0]  lz;
  logic              sgn;
  logic [LEN_W-1:0]  remaining;

  logic [CNT_W-1:0]  ndig_c;
  logic [CNT_W-1:0]  zeros;
  logic [CNT_W-1:0]  content;
  logic [CNT_W-1:0]  pad;
  logic [CNT_W-1:0]  total;
  logic [LEN_W-1:0]  len;

  logic              load;
  logic [7:0]        ch;
  logic              last;

  // field layout
  always_comb begin
    ndig_c  = CNT_W'(dig);
    zeros   = (fmt.prec_sat > ndig_c) ? fmt.prec_sat - ndig_c : '0;
    content = ndig_c + zeros + CNT_W'(fmt.has_sign);
    pad     = (fmt.width_sat > content) ? fmt.width_sat - content : '0;
    total   = pad + content;
    len     = (total > CNT_W'(OUT_LIMIT)) ? LEN_W'(OUT_LIMIT) : total[LEN_W-1:0];
  end

  assign load = (state == S_EMIT) && (!chr_valid || !chr_stall);
  assign last = (remaining == LEN_W'(1));
  assign busy = (state != S_IDLE);

  always_comb begin
    if (pre != '0) begin
      ch = CH_SPACE;
    end else if (sgn) begin
      ch = fmt.sign_char;
    end else if (lz != '0) begin
      ch = CH_ZERO;
    end else if (dig != '0) begin
      ch = CH_ZERO | {4'd0, dsr[BCD_W-1 -: 4]};
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chr_valid <= 1'b0;
    end else begin
      if (chr_valid && !chr_stall) begin
        chr_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            fmt   <= fmt_in;
            dsr   <= bcd_in;
            dig   <= ndig_in;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          pre       <= (!fmt.left && !fmt.zpad) ? pad : '0;
          lz        <= (!fmt.left && fmt.zpad) ? pad + zeros : zeros;
          sgn       <= fmt.has_sign;
          remaining <= len;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            chr_valid     <= 1'b1;
            chr.char_code <= ch;
            chr.last_char <= last;
            remaining     <= remaining - LEN_W'(1);
            if (pre != '0) begin
              pre <= pre - CNT_W'(1);
            end else if (sgn) begin
              sgn <= 1'b0;
            end else if (lz != '0) begin
              lz <= lz - CNT_W'(1);
            end else if (dig != '0) begin
              dig <= dig - NDIG_W'(1);
              dsr <= dsr << 4;
            end
            if (last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("emitter started while busy");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> remaining != '0)
    else $error("emitting with no characters left");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && last) |=> (state == S_IDLE && chr_valid && chr.last_char))
    else $error("final character did not end the item");
`endif

endmodule

`default_nettype wire

### sv/decimal_integer_formatter.sv
// top level of the decimal integer formatter
//
//   channel  dir  payload  handshake
//   num      in   num_t    num_valid / num_stall
//   chr      out  chr_t    chr_valid / chr_stall
//
// an item passes through the shift phase, the leading-zero digit strip, a hand-over step,
// a layout step and then one character per cycle while chr_stall is low (1 to 32 characters)
// the next item is taken once the final character sits in the output register
// reset clears all control state; chr_stall holds only the output register and the character sequencer
`default_nettype none

module decimal_integer_formatter
  import dif_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic num_valid,
  output logic      num_stall,
  input  wire num_t num,
  output logic      chr_valid,
  input  wire logic chr_stall,
  output chr_t      chr
);

  logic              accept;
  logic [MAG_W-1:0]  ext;
  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [CNT_W-1:0]  fw;
  logic [CNT_W-1:0]  md;
  fmt_t              fmt_now;
  fmt_t              fmt;

  logic              bcd_busy;
  logic              bcd_done;
  logic [BCD_W-1:0]  bcd;
  logic [NDIG_W-1:0] ndig;
  logic              emit_busy;

  assign num_stall = bcd_busy || bcd_done || emit_busy;
  assign accept    = num_valid && !num_stall;

  // sign and magnitude; the most negative value negates to itself unsigned
  always_comb begin
    ext = num.short_mode ? {{16{num.value[15]}}, num.value[15:0]} : num.value;
    neg = ext[MAG_W-1];
    mag = neg ? (~ext + MAG_W'(1)) : ext;
    fw  = CNT_W'(num.field_width);
    md  = CNT_W'(num.min_digits);

    fmt_now.has_sign  = neg || num.force_plus || num.space_sign;
    fmt_now.sign_char = neg ? CH_MINUS : (num.force_plus ? CH_PLUS : CH_SPACE);
    fmt_now.width_sat = (fw > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : fw;
    fmt_now.prec_sat  = (md > CNT_W'(MAX_PRECISION)) ? CNT_W'(MAX_PRECISION) : md;
    fmt_now.left      = num.left_align;
    fmt_now.zpad      = num.zero_fill && !num.force_plus && !num.left_align;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fmt <= fmt_now;
    end
  end

  dif_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .busy  (bcd_busy),
    .done  (bcd_done),
    .bcd   (bcd),
    .ndig  (ndig)
  );

  dif_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (bcd_done),
    .fmt_in    (fmt),
    .bcd_in    (bcd),
    .ndig_in   (ndig),
    .busy      (emit_busy),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

endmodule

`default_nettype wire

### sim/tb_decimal_integer_formatter.sv
// testbench for the decimal integer formatter: directed and random numbers, checked per character
`timescale 1ns / 100ps

module tb_decimal_integer_formatter;
  import dif_pkg::*;

  // flag bits of a directed item: left, plus, space, zero fill, short
  localparam logic [4:0] F_LEFT  = 5'b10000;
  localparam logic [4:0] F_PLUS  = 5'b01000;
  localparam logic [4:0] F_SPACE = 5'b00100;
  localparam logic [4:0] F_ZERO  = 5'b00010;
  localparam logic [4:0] F_SHORT = 5'b00001;

  class text_board;
    chr_t        expected_text[$];
    int unsigned mismatches;
    int unsigned numbers_taken;
    int unsigned chars_checked;

    function new();
      mismatches    = 0;
      numbers_taken = 0;
      chars_checked = 0;
    endfunction

    // works out the characters one number should turn into
    function void note_number(num_t n);
      logic [31:0] raw;
      logic        neg;
      logic [32:0] mag;
      logic [7:0]  digit_chars[12];
      logic [7:0]  text[$];
      logic [7:0]  sign_char;
      logic        sign_done;
      int          ndig, zeros, width, prec, content, pad, len, k;
      chr_t        c;
      raw = n.value;
      if (n.short_mode) begin
        neg = raw[15];
        mag = neg ? 33'h10000 - {17'd0, raw[15:0]} : {17'd0, raw[15:0]};
      end else begin
        neg = raw[31];
        mag = neg ? 33'h100000000 - {1'b0, raw} : {1'b0, raw};
      end
      width = (n.field_width > MAX_WIDTH) ? MAX_WIDTH : int'(n.field_width);
      prec  = (n.min_digits > MAX_PRECISION) ? MAX_PRECISION : int'(n.min_digits);
      // least significant digit first; zero still gives one digit
      ndig = 0;
      do begin
        digit_chars[ndig] = CH_ZERO + 8'(mag % 10);
        mag = mag / 10;
        ndig++;
      end while (mag != 0);
      zeros = (prec > ndig) ? prec - ndig : 0;
      if (neg)
        sign_char = CH_MINUS;
      else if (n.force_plus)
        sign_char = CH_PLUS;
      else if (n.space_sign)
        sign_char = CH_SPACE;
      else
        sign_char = 8'h00;
      content   = ndig + zeros + ((sign_char != 8'h00) ? 1 : 0);
      pad       = (width > content) ? width - content : 0;
      sign_done = 1'b0;
      if (pad > 0 && !n.left_align) begin
        if (n.zero_fill && !n.force_plus) begin
          // the sign goes ahead of the padding zeros
          if (sign_char != 8'h00)
            text.push_back(sign_char);
          sign_done = 1'b1;
          repeat (pad) text.push_back(CH_ZERO);
        end else begin
          repeat (pad) text.push_back(CH_SPACE);
        end
      end
      if (sign_char != 8'h00 && !sign_done)
        text.push_back(sign_char);
      repeat (zeros) text.push_back(CH_ZERO);
      for (k = ndig; k > 0; k--)
        text.push_back(digit_chars[k - 1]);
      if (n.left_align)
        repeat (pad) text.push_back(CH_SPACE);
      len = (text.size() > OUT_LIMIT) ? OUT_LIMIT : text.size();
      for (k = 0; k < len; k++) begin
        c.char_code = text[k];
        c.last_char = (k + 1 == len);
        expected_text.push_back(c);
      end
      numbers_taken++;
    endfunction

    function void flag(string what, chr_t want, chr_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected char %h last %b, got char %h last %b", $time, what,
                 want.char_code, want.last_char, got.char_code, got.last_char);
    endfunction

    function void check_char(chr_t got);
      chr_t want;
      chars_checked++;
      if (expected_text.size() == 0) begin
        want = '0;
        flag("character with none expected", want, got);
      end else begin
        want = expected_text.pop_front();
        if (got.char_code != want.char_code)
          flag("wrong character", want, got);
        else if (got.last_char != want.last_char)
          flag("wrong end mark", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        num_valid = 1'b0;
  logic        num_stall;
  num_t        num = '0;
  logic        chr_valid;
  logic        chr_stall = 1'b0;
  chr_t        chr;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  text_board   board = new();

  decimal_integer_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .num       (num),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

  always #10 clk = ~clk;

  // output side: check what was taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (!rst && chr_valid === 1'b1 && !chr_stall)
      board.check_char(chr);
    chr_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic send_number(input num_t n);
    while ($urandom_range(99) < send_idle) begin
      num_valid <= 1'b0;
      @(posedge clk);
    end
    num_valid <= 1'b1;
    num       <= n;
    @(posedge clk);
    while (num_stall)
      @(posedge clk);
    board.note_number(n);
  endtask

  function automatic num_t mk(input int v, input int w, input int p, input logic [4:0] f);
    num_t n;
    n.value       = v;
    n.field_width = 6'(w);
    n.min_digits  = 5'(p);
    n.left_align  = f[4];
    n.force_plus  = f[3];
    n.space_sign  = f[2];
    n.zero_fill   = f[1];
    n.short_mode  = f[0];
    return n;
  endfunction

  function automatic num_t random_number();
    num_t n;
    int   v;
    int   p10;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: begin
        v = $urandom_range(99999);
        if ($urandom_range(1)) v = -v;
      end
      3: begin
        // boundaries around powers of ten
        p10 = 1;
        repeat ($urandom_range(9)) p10 = p10 * 10;
        v = p10 + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = -v;
      end
      4: begin
        case ($urandom_range(6))
          0: v = 32'h80000000;
          1: v = 32'h7fffffff;
          2: v = 32'h00008000;
          3: v = 32'h00007fff;
          4: v = -1;
          5: v = 32'hffff8000;
          default: v = 0;
        endcase
      end
      default: v = {16'($urandom_range(65535)), 16'($urandom_range(65535))};
    endcase
    n.value       = v;
    n.field_width = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(16));
    n.min_digits  = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(12));
    n.left_align  = 1'($urandom_range(1));
    n.force_plus  = 1'($urandom_range(1));
    n.space_sign  = 1'($urandom_range(1));
    n.zero_fill   = 1'($urandom_range(1));
    n.short_mode  = ($urandom_range(3) == 0);
    return n;
  endfunction

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_number(mk(0, 0, 0, 5'b0));
    send_number(mk(0, 0, 5, 5'b0));
    send_number(mk(32'h7fffffff, 0, 0, F_PLUS));
    send_number(mk(32'h80000000, 0, 0, 5'b0));
    send_number(mk(32'h80000000, 40, 0, F_ZERO));
    send_number(mk(32'h00018000, 0, 0, F_SHORT));
    send_number(mk(32'hffff7fff, 8, 0, F_SHORT | F_PLUS));
    send_number(mk(-1, 6, 0, F_ZERO));
    send_number(mk(42, 8, 0, F_SPACE | F_ZERO));
    send_number(mk(42, 8, 0, F_PLUS | F_ZERO));
    send_number(mk(42, 8, 0, F_LEFT | F_ZERO));
    send_number(mk(-42, 8, 4, F_LEFT));
    send_number(mk(7, 63, 31, 5'b0));
    send_number(mk(123, 0, 31, F_SPACE));
    send_number(mk(5, 0, 0, F_PLUS | F_SPACE));
    send_number(mk(-7, 10, 3, F_SPACE | F_ZERO));
    send_number(mk(0, 32, 16, 5'b11111));
    send_number(mk(1000000000, 11, 0, F_SPACE));
    send_number(mk(-123456789, 32, 16, F_LEFT | F_PLUS));
    send_number(mk(32'h0000ffff, 4, 0, F_SHORT | F_ZERO));
    send_number(mk(99, 2, 2, 5'b0));

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 76; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 76; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      repeat (90) send_number(random_number());
    end
    num_valid <= 1'b0;

    while (board.expected_text.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d numbers formatted under four idle and stall mixes, %0d characters checked",
             board.numbers_taken, board.chars_checked);
    $display("%0d mismatches, %0d characters still awaited", board.mismatches,
             board.expected_text.size());
    if (board.mismatches == 0 && board.expected_text.size() == 0)
      $display("tb_decimal_integer_formatter: done, clean");
    else
      $display("tb_decimal_integer_formatter: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timed out with %0d characters awaited", board.expected_text.size());
    $display("tb_decimal_integer_formatter: done, errors");
    $finish;
  end

endmodule
